### sv/fta_pkg.sv
// fta_pkg: shared types and constants for the frame time averager
// holds the sequencer state type, the control bundle and fixed field widths
// no dependencies
package fta_pkg;

  localparam int unsigned TS_W   = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned WIN_W  = 33;
  localparam int unsigned FC_W   = 24;
  localparam int unsigned STEP_W = 6;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME     = 1'b1;

  localparam logic [WORD_W-1:0] TPS_RESET = 32'd10000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELAPSED,
    ST_PREP,
    ST_SPREAD,
    ST_ACCUM,
    ST_COMMIT,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              accept;
    logic              first;
    logic              run_a;
    logic              prep;
    logic              run_b;
    logic              run_c;
    logic              commit;
    logic              run_d;
    logic              last;
    logic              emit;
    logic              done;
    logic [STEP_W-1:0] cnt;
  } ctl_t;

endpackage

### sv/frame_time_averager_fps_meter.sv
// frame_time_averager_fps_meter: top level of the frame time averager
// depends on fta_pkg, fta_ctrl, fta_elapsed, fta_stats and fta_div
//
// usage
//   input channel: one beat per poll of the free-running tick counter
//   (timestamp_i), taken when in_valid_i is high and in_stall_o is low.
//   output channel: one beat per poll with frame, average and rate fields,
//   offered on out_valid_o and held while out_stall_i is high.
//   configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 ticks per second, 1 minimum frame ticks); write only while idle.
// sequence
//   the first poll after reset only records its timestamp and goes to the
//   output beat. a poll held by the frame lock ends after the subtract. a
//   completed frame runs every pass: the 64-bit serial subtract, the 32-bit
//   serial outlier test, the serial sum and window update and the restoring
//   divide; sum and divide run over SUM_W bits, 32 + log2 of the depth. each
//   goes a bit per cycle, back to back, for one poll at a time.
// reset and back-pressure
//   reset clears all control and statistics; the sample ring needs no clear.
//   a finished beat waits in the output register while out_stall_i is high;
//   the next poll can still be taken, and its beat is held until that one has left.
module frame_time_averager_fps_meter import fta_pkg::*; #(
  parameter int unsigned SAMPLE_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [TS_W-1:0]      timestamp_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 frame_done_o,
  output logic [WORD_W-1:0]    frame_ticks_o,
  output logic                 sample_taken_o,
  output logic [WORD_W-1:0]    avg_frame_ticks_o,
  output logic [FC_W-1:0]      frame_rate_o,
  output logic                 rate_updated_o
);

  localparam int unsigned CNT_W = $clog2(SAMPLE_DEPTH + 1);

  ctl_t              ctl;
  logic [WORD_W-1:0] tps_q, min_q;
  logic              out_valid_q;
  logic              out_free;
  logic              lock_wait;
  logic [WORD_W-1:0] ticks;
  logic [WORD_W-1:0] avg;
  logic              taken;
  logic              sum_msb;
  logic [CNT_W-1:0]  count;
  logic [FC_W-1:0]   rate;
  logic              updated;
  logic              done_q;
  logic [WORD_W-1:0] ticks_q;
  logic              taken_q;
  logic [WORD_W-1:0] avg_q;
  logic [FC_W-1:0]   rate_q;
  logic              upd_q;

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
      min_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TICKS_PER_SEC: tps_q <= cfg_wdata_i;
        CFG_MIN_FRAME:     min_q <= cfg_wdata_i;
        default:           tps_q <= tps_q;
      endcase
    end
  end

  fta_ctrl #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .lock_wait_i(lock_wait),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl)
  );

  fta_elapsed u_elapsed (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .timestamp_i      (timestamp_i),
    .min_frame_ticks_i(min_q),
    .lock_wait_o      (lock_wait),
    .ticks_o          (ticks)
  );

  fta_stats #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_stats (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .ticks_i        (ticks),
    .ticks_per_sec_i(tps_q),
    .avg_i          (avg),
    .taken_o        (taken),
    .sum_msb_o      (sum_msb),
    .count_o        (count),
    .rate_o         (rate),
    .updated_o      (updated)
  );

  fta_div #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sum_msb_i(sum_msb),
    .count_i  (count),
    .avg_o    (avg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      done_q  <= ctl.done;
      ticks_q <= ctl.done ? ticks : '0;
      taken_q <= ctl.done & taken;
      avg_q   <= avg;
      rate_q  <= rate;
      upd_q   <= updated;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_done_o      = done_q;
  assign frame_ticks_o     = ticks_q;
  assign sample_taken_o    = taken_q;
  assign avg_frame_ticks_o = avg_q;
  assign frame_rate_o      = rate_q;
  assign rate_updated_o    = upd_q;

endmodule

### sv/fta_ctrl.sv
// fta_ctrl: sequencer for the bit-serial passes of one poll
// depends on fta_pkg for the state type and the control bundle
module fta_ctrl import fta_pkg::*; #(
  parameter int unsigned SAMPLE_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic lock_wait_i,
  input  logic out_free_i,
  output logic in_stall_o,
  output ctl_t ctl_o
);

  localparam int unsigned SUM_W = WORD_W + $clog2(SAMPLE_DEPTH);
  localparam logic [STEP_W-1:0] SUM_LAST = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] TS_LAST  = STEP_W'(TS_W - 1);
  localparam logic [STEP_W-1:0] WORD_LAST = STEP_W'(WORD_W - 1);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              started_q, started_d;
  logic              done_q, done_d;
  logic              last;

  always_comb begin
    case (state_q)
      ST_ELAPSED: last = (cnt_q == TS_LAST);
      ST_SPREAD:  last = (cnt_q == WORD_LAST);
      ST_ACCUM:   last = (cnt_q == SUM_LAST);
      ST_DIVIDE:  last = (cnt_q == SUM_LAST);
      default:    last = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = started_q ? ST_ELAPSED : ST_EMIT;
        end
      end
      ST_ELAPSED: if (last) state_d = ST_PREP;
      ST_PREP:    state_d = lock_wait_i ? ST_EMIT : ST_SPREAD;
      ST_SPREAD:  if (last) state_d = ST_ACCUM;
      ST_ACCUM:   if (last) state_d = ST_COMMIT;
      ST_COMMIT:  state_d = ST_DIVIDE;
      ST_DIVIDE:  if (last) state_d = ST_EMIT;
      ST_EMIT:    if (out_free_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d     = (state_d != state_q) ? '0 : cnt_q + 1'b1;
    started_d = started_q | (state_q == ST_IDLE && in_valid_i);
    done_d    = done_q;
    if (state_q == ST_IDLE && in_valid_i) begin
      done_d = 1'b0;
    end else if (state_q == ST_PREP && !lock_wait_i) begin
      done_d = 1'b1;
    end
  end

  // outputs
  always_comb begin
    ctl_o        = '0;
    ctl_o.cnt    = cnt_q;
    ctl_o.last   = last;
    ctl_o.done   = done_q;
    in_stall_o   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        ctl_o.accept = in_valid_i;
        ctl_o.first  = in_valid_i & ~started_q;
      end
      ST_ELAPSED: ctl_o.run_a  = 1'b1;
      ST_PREP:    ctl_o.prep   = 1'b1;
      ST_SPREAD:  ctl_o.run_b  = 1'b1;
      ST_ACCUM:   ctl_o.run_c  = 1'b1;
      ST_COMMIT:  ctl_o.commit = 1'b1;
      ST_DIVIDE:  ctl_o.run_d  = 1'b1;
      ST_EMIT:    ctl_o.emit   = out_free_i;
      default:    ctl_o.cnt    = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      started_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
      done_q    <= done_d;
    end
  end

endmodule

### sv/fta_elapsed.sv
// fta_elapsed: bit-serial timestamp difference, lock compare and saturation
// depends on fta_pkg for widths and the control bundle
module fta_elapsed import fta_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_t              ctl_i,
  input  logic [TS_W-1:0]   timestamp_i,
  input  logic [WORD_W-1:0] min_frame_ticks_i,
  output logic              lock_wait_o,
  output logic [WORD_W-1:0] ticks_o
);

  logic [TS_W-1:0]   now_q, last_q, el_q;
  logic [WORD_W-1:0] mn_q;
  logic              br_q, br_d;
  logic              lt_q, lt_d;
  logic              hi_q, hi_d;
  logic              lock_q;
  logic              a_b, l_b, m_b, d_b;

  always_comb begin
    a_b  = now_q[0];
    l_b  = last_q[0];
    m_b  = mn_q[0];
    d_b  = a_b ^ l_b ^ br_q;
    br_d = (~a_b & l_b) | (~(a_b ^ l_b) & br_q);
    lt_d = (d_b != m_b) ? m_b : lt_q;
    hi_d = hi_q | (d_b & (ctl_i.cnt >= STEP_W'(WORD_W)));
  end

  assign lock_wait_o = lock_q & lt_q;
  assign ticks_o     = hi_q ? '1 : el_q[WORD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_q   <= 1'b0;
      lt_q   <= 1'b0;
      hi_q   <= 1'b0;
      lock_q <= 1'b0;
    end else if (ctl_i.accept) begin
      br_q   <= 1'b0;
      lt_q   <= 1'b0;
      hi_q   <= 1'b0;
      lock_q <= |min_frame_ticks_i;
    end else if (ctl_i.run_a) begin
      br_q <= br_d;
      lt_q <= lt_d;
      hi_q <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      now_q <= timestamp_i;
      mn_q  <= min_frame_ticks_i;
    end else if (ctl_i.run_a) begin
      now_q <= {now_q[0], now_q[TS_W-1:1]};
      mn_q  <= {1'b0, mn_q[WORD_W-1:1]};
      el_q  <= {d_b, el_q[TS_W-1:1]};
    end
    if (ctl_i.first) begin
      last_q <= timestamp_i;
    end else if (ctl_i.run_a) begin
      last_q <= {last_q[0], last_q[TS_W-1:1]};
    end else if (ctl_i.prep && !lock_wait_o) begin
      last_q <= now_q;
    end
  end

endmodule

### sv/fta_stats.sv
// fta_stats: sample ring, bit-serial outlier test, window sum and rate window
// depends on fta_pkg for widths and the control bundle
module fta_stats import fta_pkg::*; #(
  parameter int unsigned SAMPLE_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ctl_t                              ctl_i,
  input  logic [WORD_W-1:0]                 ticks_i,
  input  logic [WORD_W-1:0]                 ticks_per_sec_i,
  input  logic [WORD_W-1:0]                 avg_i,
  output logic                              taken_o,
  output logic                              sum_msb_o,
  output logic [$clog2(SAMPLE_DEPTH+1)-1:0] count_o,
  output logic [FC_W-1:0]                   rate_o,
  output logic                              updated_o
);

  localparam int unsigned SUM_W = WORD_W + $clog2(SAMPLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned PTR_W = $clog2(SAMPLE_DEPTH);

  logic [WORD_W-1:0] ring_mem [SAMPLE_DEPTH];
  logic [WORD_W-1:0] tk_sh_q, tp_sh_q, av_sh_q, old_sh_q;
  logic [PTR_W-1:0]  ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic [SUM_W-1:0]  sum_q;
  logic [WIN_W-1:0]  win_q;
  logic [FC_W-1:0]   fc_q, fc_inc;
  logic [FC_W-1:0]   rate_q;
  logic              upd_q;
  logic              b1_q, b2_q, lt1_q, lt2_q;
  logic              c1_q, b3_q, c2_q, gt_q;
  logic              full, lo, win_on;
  logic              t_b, v_b, p_b, d1, d2;
  logic              add_b, sub_b, s_b, x_b, y_b, tw_b, w_b, wn_b, pc_b;

  assign full    = (count_q == CNT_W'(SAMPLE_DEPTH));
  assign lo      = (ctl_i.cnt < STEP_W'(WORD_W));
  assign win_on  = (ctl_i.cnt < STEP_W'(WIN_W));
  assign taken_o = b1_q ? lt2_q : lt1_q;
  assign fc_inc  = (fc_q == '1) ? fc_q : fc_q + 1'b1;

  always_comb begin
    t_b   = tk_sh_q[0];
    v_b   = av_sh_q[0];
    p_b   = tp_sh_q[0];
    d1    = t_b ^ v_b ^ b1_q;
    d2    = v_b ^ t_b ^ b2_q;
    // sum pass: sum + new sample - dropped sample
    add_b = taken_o & lo & t_b;
    sub_b = taken_o & full & lo & old_sh_q[0];
    s_b   = sum_q[0];
    x_b   = s_b ^ add_b ^ c1_q;
    y_b   = x_b ^ sub_b ^ b3_q;
    // window pass
    tw_b  = lo & t_b;
    w_b   = win_q[0];
    wn_b  = w_b ^ tw_b ^ c2_q;
    pc_b  = lo & p_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_q  <= 1'b0;
      b2_q  <= 1'b0;
      lt1_q <= 1'b0;
      lt2_q <= 1'b0;
      c1_q  <= 1'b0;
      b3_q  <= 1'b0;
      c2_q  <= 1'b0;
      gt_q  <= 1'b0;
    end else if (ctl_i.accept) begin
      b1_q  <= 1'b0;
      b2_q  <= 1'b0;
      lt1_q <= 1'b0;
      lt2_q <= 1'b0;
      c1_q  <= 1'b0;
      b3_q  <= 1'b0;
      c2_q  <= 1'b0;
      gt_q  <= 1'b0;
    end else if (ctl_i.run_b) begin
      b1_q  <= (~t_b & v_b) | (~(t_b ^ v_b) & b1_q);
      b2_q  <= (~v_b & t_b) | (~(t_b ^ v_b) & b2_q);
      lt1_q <= (d1 != p_b) ? p_b : lt1_q;
      lt2_q <= (d2 != p_b) ? p_b : lt2_q;
    end else if (ctl_i.run_c) begin
      c1_q <= (s_b & add_b) | (s_b & c1_q) | (add_b & c1_q);
      b3_q <= (~x_b & sub_b) | (~(x_b ^ sub_b) & b3_q);
      if (win_on) begin
        c2_q <= (w_b & tw_b) | (w_b & c2_q) | (tw_b & c2_q);
        gt_q <= (wn_b != pc_b) ? wn_b : gt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      count_q <= '0;
      sum_q   <= '0;
      win_q   <= '0;
      fc_q    <= '0;
      rate_q  <= '0;
      upd_q   <= 1'b0;
    end else begin
      if (ctl_i.accept) begin
        upd_q <= 1'b0;
      end
      if (ctl_i.run_c) begin
        sum_q <= {y_b, sum_q[SUM_W-1:1]};
        if (win_on) begin
          win_q <= {wn_b, win_q[WIN_W-1:1]};
        end
      end else if (ctl_i.run_d) begin
        sum_q <= {sum_q[SUM_W-2:0], sum_q[SUM_W-1]};
      end
      if (ctl_i.commit) begin
        if (taken_o) begin
          ptr_q <= (ptr_q == PTR_W'(SAMPLE_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
          if (!full) begin
            count_q <= count_q + 1'b1;
          end
        end
        if (gt_q) begin
          rate_q <= fc_inc;
          fc_q   <= '0;
          win_q  <= '0;
          upd_q  <= 1'b1;
        end else begin
          fc_q <= fc_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.prep) begin
      tk_sh_q  <= ticks_i;
      tp_sh_q  <= ticks_per_sec_i;
      av_sh_q  <= avg_i;
      old_sh_q <= ring_mem[ptr_q];
    end else if (ctl_i.run_b) begin
      tk_sh_q <= {tk_sh_q[0], tk_sh_q[WORD_W-1:1]};
      tp_sh_q <= {tp_sh_q[0], tp_sh_q[WORD_W-1:1]};
      av_sh_q <= {1'b0, av_sh_q[WORD_W-1:1]};
    end else if (ctl_i.run_c && lo) begin
      tk_sh_q  <= {tk_sh_q[0], tk_sh_q[WORD_W-1:1]};
      tp_sh_q  <= {tp_sh_q[0], tp_sh_q[WORD_W-1:1]};
      old_sh_q <= {1'b0, old_sh_q[WORD_W-1:1]};
    end
    if (ctl_i.commit && taken_o) begin
      ring_mem[ptr_q] <= tk_sh_q;
    end
  end

  assign sum_msb_o = sum_q[SUM_W-1];
  assign count_o   = count_q;
  assign rate_o    = rate_q;
  assign updated_o = upd_q;

endmodule

### sv/fta_div.sv
// fta_div: restoring divider, one quotient bit per cycle, for the window average
// depends on fta_pkg for widths and the control bundle
module fta_div import fta_pkg::*; #(
  parameter int unsigned SAMPLE_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ctl_t                              ctl_i,
  input  logic                              sum_msb_i,
  input  logic [$clog2(SAMPLE_DEPTH+1)-1:0] count_i,
  output logic [WORD_W-1:0]                 avg_o
);

  localparam int unsigned CNT_W = $clog2(SAMPLE_DEPTH + 1);

  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic [WORD_W-1:0] quo_q, quo_d;
  logic [WORD_W-1:0] avg_q;

  always_comb begin
    trial = {rem_q, sum_msb_i};
    ge    = (trial >= {1'b0, count_i});
    quo_d = {quo_q[WORD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (ctl_i.run_d && ctl_i.last) begin
      avg_q <= (count_i == '0) ? '0 : quo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      rem_q <= '0;
    end else if (ctl_i.run_d) begin
      rem_q <= ge ? CNT_W'(trial - {1'b0, count_i}) : CNT_W'(trial);
      quo_q <= quo_d;
    end
  end

  assign avg_o = avg_q;

endmodule

### sv/fta_checker.sv
// fta_checker: port-level checks for the frame time averager, bound to the top
// depends on fta_pkg for widths and on frame_time_averager_fps_meter for the bind
module fta_checker import fta_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 frame_done_o,
  input logic [WORD_W-1:0]    frame_ticks_o,
  input logic                 sample_taken_o,
  input logic [WORD_W-1:0]    avg_frame_ticks_o,
  input logic [FC_W-1:0]      frame_rate_o,
  input logic                 rate_updated_o
);

  // one poll in flight at a time
  a_poll_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("poll accepted while a previous poll is in flight");

  a_idle_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |->
      frame_ticks_o == '0 && !sample_taken_o && !rate_updated_o)
    else $error("beat without a frame carries frame fields");

  a_rate_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rate_updated_o |-> frame_done_o && frame_rate_o != '0)
    else $error("rate window closed with no frame counted");

  a_sample_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_taken_o |-> frame_done_o)
    else $error("sample taken on a beat without a frame");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_ticks_o)
      && $stable(avg_frame_ticks_o))
    else $error("stalled output beat changed");

endmodule

bind frame_time_averager_fps_meter fta_checker u_fta_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .frame_done_o     (frame_done_o),
  .frame_ticks_o    (frame_ticks_o),
  .sample_taken_o   (sample_taken_o),
  .avg_frame_ticks_o(avg_frame_ticks_o),
  .frame_rate_o     (frame_rate_o),
  .rate_updated_o   (rate_updated_o)
);
